/* hdl/cpc_pkg.sv */
// Package for the contrast pixel counter: field widths, register indexes,
// reset values and the types that pass between the pixel cells.
// No dependencies.
`timescale 1ns / 1ps

package cpc_pkg;

  localparam int PIX_W       = 8;
  localparam int THR_W       = 8;
  localparam int COLS_REG_W  = 10;
  localparam int ROWS_REG_W  = 11;
  localparam int TOTAL_W     = 20;
  localparam int INC_W       = 2;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd2;

  localparam logic [THR_W-1:0]      THRESHOLD_RST   = 8'd128;
  localparam logic [COLS_REG_W-1:0] COLS_IN_USE_RST = 10'd320;
  localparam logic [ROWS_REG_W-1:0] ROWS_IN_USE_RST = 11'd200;

  // One pixel item travelling down the cell chain.
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] pix;
    logic [THR_W-1:0] thr;   // threshold captured at accept
    logic             up;    // a row above exists
    logic             lrow;  // item lies in the frame's last row
    logic             lcol;  // item ends its row
    logic [INC_W-1:0] inc;   // count added by this item
  } tok_t;

  // Line store entry held by one cell.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             mark;
  } nbr_t;

endpackage

/* hdl/cpc_cell.sv */
// One cell of the contrast pixel counter chain: holds the line store entry
// of its column and does the compares for the item of that column.
// Depends on cpc_pkg.
`timescale 1ns / 1ps

module cpc_cell import cpc_pkg::*; #(
  parameter int INDEX = 0,
  parameter int COL_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  tok_t             tok_in,
  input  logic [COL_W-1:0] col_in,
  output tok_t             tok_out,
  output logic [COL_W-1:0] col_out,
  input  nbr_t             left,
  output logic             left_set,
  input  logic             right_set,
  output nbr_t             store
);

  localparam bit HAS_LEFT = (INDEX > 0);

  tok_t             tok;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] spix;
  logic             smark;

  logic             hit;
  logic             up_cmp;
  logic             left_cmp;
  logic             cur_mark;
  logic             up_final;
  logic             left_final;
  logic [INC_W-1:0] inc;

  function automatic logic contrasts(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                     input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

  always_comb begin
    hit        = tok.vld && (col == COL_W'(INDEX));
    up_cmp     = tok.up && contrasts(tok.pix, spix, tok.thr);
    left_cmp   = HAS_LEFT && contrasts(tok.pix, left.pix, tok.thr);
    cur_mark   = up_cmp || left_cmp;
    // right neighbor may set this entry's mark in the same cycle
    up_final   = up_cmp || smark || right_set;
    left_final = left_cmp || left.mark;
    inc = INC_W'(tok.up && up_final)
        + INC_W'(tok.lrow && HAS_LEFT && left_final)
        + INC_W'(tok.lrow && tok.lcol && cur_mark);
  end

  always_comb begin
    tok_out = tok;
    if (hit) begin
      tok_out.inc = inc;
    end
  end

  assign col_out   = col;
  assign left_set  = hit && left_cmp;
  assign store.pix  = spix;
  assign store.mark = smark;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
    end else if (en) begin
      tok <= tok_in;
      col <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hit) begin
        spix  <= tok.pix;
        smark <= cur_mark;
      end else if (right_set) begin
        smark <= 1'b1;
      end
    end
  end

endmodule

/* hdl/contrast_pixel_counter_unit.sv */
// Contrast pixel counter top level: config registers, raster position
// counters, the chain of column cells and the frame total accumulator.
// Depends on cpc_pkg and cpc_cell.
`timescale 1ns / 1ps

// Takes one 8-bit grey pixel per clock in raster order and, after the last
// pixel of each frame, gives the number of pixels that differ by more than
// threshold from at least one 4-neighbor. Each pixel walks a chain of
// MAX_COLS cells, one per column, each holding that column's pixel and mark
// from the row above; the item does its compares in the cell of its column.
// A new item is taken every cycle unless the chain holds; the frame total
// passes through the MAX_COLS cells of the chain and is then registered.
// While a total waits unread and the next one reaches the chain end, the
// whole chain holds. Config changes apply to items accepted afterwards.

module contrast_pixel_counter_unit import cpc_pkg::*; #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [19:0] contrast_total, rest zero
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CSW   = (COL_W + 1 > COLS_REG_W) ? COL_W + 1 : COLS_REG_W;
  localparam int RSW   = (ROW_W + 1 > ROWS_REG_W) ? ROW_W + 1 : ROWS_REG_W;

  logic [THR_W-1:0]      threshold;
  logic [COLS_REG_W-1:0] cols_in_use;
  logic [ROWS_REG_W-1:0] rows_in_use;

  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [CSW-1:0]   cols_eff;
  logic [RSW-1:0]   rows_eff;
  logic             last_col;
  logic             last_row;

  logic               en;
  logic               end_res;
  logic [TOTAL_W-1:0] running_total;
  logic [TOTAL_W-1:0] total_sum;
  logic [TOTAL_W-1:0] total_q;

  tok_t             tok_c [0:MAX_COLS];
  logic [COL_W-1:0] col_c [0:MAX_COLS-1];
  nbr_t             nbr   [0:MAX_COLS-2];
  logic             set_bk [1:MAX_COLS];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RST;
      cols_in_use <= COLS_IN_USE_RST;
      rows_in_use <= ROWS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        REG_COLS_IN_USE: cols_in_use <= cfg_data[COLS_REG_W-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size, zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cols_in_use == '0) begin
      cols_eff = CSW'(1);
    end else if (CSW'(cols_in_use) > CSW'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      rows_eff = RSW'(1);
    end else if (RSW'(rows_in_use) > RSW'(MAX_ROWS)) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(rows_in_use);
    end
    last_col = (CSW'(col_pos) + CSW'(1)) >= cols_eff;
    last_row = (RSW'(row_pos) + RSW'(1)) >= rows_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (s_tvalid && s_tready) begin
      if (last_col) begin
        col_pos <= '0;
        if (last_row) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_pos + ROW_W'(1);
        end
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // chain head
  always_comb begin
    tok_c[0].vld  = s_tvalid;
    tok_c[0].pix  = s_tdata[PIX_W-1:0];
    tok_c[0].thr  = threshold;
    tok_c[0].up   = (row_pos != '0);
    tok_c[0].lrow = last_row;
    tok_c[0].lcol = last_col;
    tok_c[0].inc  = '0;
    col_c[0]      = col_pos;
  end

  assign set_bk[MAX_COLS] = 1'b0;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      cpc_cell #(.INDEX(i), .COL_W(COL_W)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .tok_in    (tok_c[i]),
        .col_in    (col_c[i]),
        .tok_out   (tok_c[i+1]),
        .col_out   (col_c[i+1]),
        .left      ('0),
        .left_set  (),
        .right_set (set_bk[i+1]),
        .store     (nbr[i])
      );
    end else if (i == MAX_COLS - 1) begin : g_last
      cpc_cell #(.INDEX(i), .COL_W(COL_W)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .tok_in    (tok_c[i]),
        .col_in    (col_c[i]),
        .tok_out   (tok_c[i+1]),
        .col_out   (),
        .left      (nbr[i-1]),
        .left_set  (set_bk[i]),
        .right_set (set_bk[i+1]),
        .store     ()
      );
    end else begin : g_mid
      cpc_cell #(.INDEX(i), .COL_W(COL_W)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .tok_in    (tok_c[i]),
        .col_in    (col_c[i]),
        .tok_out   (tok_c[i+1]),
        .col_out   (col_c[i+1]),
        .left      (nbr[i-1]),
        .left_set  (set_bk[i]),
        .right_set (set_bk[i+1]),
        .store     (nbr[i])
      );
    end
  end

  // chain tail: frame total
  assign end_res   = tok_c[MAX_COLS].vld && tok_c[MAX_COLS].lrow && tok_c[MAX_COLS].lcol;
  assign en        = !(m_tvalid && !m_tready && end_res);
  assign s_tready  = en;
  assign total_sum = running_total + TOTAL_W'(tok_c[MAX_COLS].inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (en && tok_c[MAX_COLS].vld) begin
      if (end_res) begin
        running_total <= '0;
      end else begin
        running_total <= total_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && end_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && end_res) begin
      total_q <= total_sum;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - TOTAL_W)'(0), total_q};

endmodule
